// File: hdl/mlfq_pkg.sv
package mlfq_pkg;
  localparam int TASKS  = 64;
  localparam int LEVELS = 4;
  localparam int TW     = 6;   // task index width
  localparam int LW     = 2;   // level width
  localparam logic [6:0] NIL = 7'd127;

  localparam logic [2:0] K_INSERT   = 3'd0;
  localparam logic [2:0] K_REMOVE   = 3'd1;
  localparam logic [2:0] K_YIELD    = 3'd2;
  localparam logic [2:0] K_SETRUN   = 3'd3;
  localparam logic [2:0] K_DISPATCH = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRIO    = 2'd1;
  localparam logic [1:0] ST_NOTQ    = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  localparam logic [1:0] CFG_L0 = 2'd0;
  localparam logic [1:0] CFG_L1 = 2'd1;
  localparam logic [1:0] CFG_L2 = 2'd2;
  localparam logic [1:0] CFG_L3 = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] task_req;
    logic [7:0] priority_req;
    logic       runnable;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] task_out;
    logic [1:0] level_out;
  } rsp_t;
endpackage

// File: hdl/mlfq_if.sv
interface mlfq_req_if import mlfq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlfq_rsp_if import mlfq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/multilevel_feedback_task_queue.sv
// Insert/yield of a queued task walks its level list to unlink it, then appends
//   if a level fits; an unqueued insert that fits appends directly; remove walks
//   and unlinks; dispatch scans levels from 0 up. One item at a time.
// The link RAM and level RAM have a registered read, one write port and one read port.
// Reset: synchronous, active high; heads/tails empty, queued/ready flags
//   cleared, limits 1,3,5,7. Link and level RAMs are not cleared.
module multilevel_feedback_task_queue import mlfq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  mlfq_req_if.sink    req,
  mlfq_rsp_if.source  rsp
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LVL   = 9'b000000010,
    S_WALK  = 9'b000000100,
    S_WAIT  = 9'b000001000,
    S_UNL   = 9'b000010000,
    S_APP   = 9'b000100000,
    S_DSCAN = 9'b001000000,
    S_DWAIT = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [7:0] lim [LEVELS];
  logic [6:0] head [LEVELS];
  logic [6:0] tail [LEVELS];
  logic [TASKS-1:0] queued, ready_f;

  // memories
  logic [6:0] link_mem [TASKS];
  logic [1:0] lvl_mem  [TASKS];
  logic [6:0] link_q;
  logic [1:0] lvl_q;
  logic       lk_we;
  logic [TW-1:0] lk_wa, lk_ra;
  logic [6:0] lk_wd;
  logic       lv_we;
  logic [1:0] lv_wd;

  req_t r;
  rsp_t res;
  logic [6:0] cur, prev;
  logic [1:0] lvl, dst;
  logic [6:0] steps;
  logic       do_app;

  always_ff @(posedge clk) begin
    if (lk_we) link_mem[lk_wa] <= lk_wd;
    if (lv_we) lvl_mem[lk_wa] <= lv_wd;
    link_q <= link_mem[lk_ra];
    lvl_q  <= lvl_mem[lk_ra];
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data  = res;

  // first level that fits
  logic       fit;
  logic [1:0] fit_lvl;
  always_comb begin
    fit = 1'b0;
    fit_lvl = '0;
    for (int i = LEVELS-1; i >= 0; i--) begin
      if (r.priority_req <= lim[i]) begin
        fit = 1'b1;
        fit_lvl = LW'(i);
      end
    end
  end

  always_comb begin
    lk_we = 1'b0;
    lv_we = 1'b0;
    lk_wa = r.task_req;
    lk_wd = NIL;
    lv_wd = dst;
    lk_ra = r.task_req;
    unique case (state)
      S_IDLE:  lk_ra = req.data.task_req;
      S_WALK:  lk_ra = cur[TW-1:0];
      S_DSCAN: lk_ra = cur[TW-1:0];
      S_UNL: begin
        if (prev != NIL) begin
          lk_we = 1'b1;
          lk_wa = prev[TW-1:0];
          lk_wd = link_q;
        end
      end
      S_APP: begin
        // own link and level first, tail link next cycle via do_app
        if (!do_app) begin
          lk_we = 1'b1;
          lv_we = 1'b1;
          lk_wa = r.task_req;
          lk_wd = NIL;
        end else if (head[dst] != NIL && tail[dst] != NIL) begin
          lk_we = 1'b1;
          lk_wa = tail[dst][TW-1:0];
          lk_wd = {1'b0, r.task_req};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      lim[0]  <= 8'd1;
      lim[1]  <= 8'd3;
      lim[2]  <= 8'd5;
      lim[3]  <= 8'd7;
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= NIL;
        tail[i] <= NIL;
      end
      queued  <= '0;
      ready_f <= '0;
      do_app  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_L0: lim[0] <= cfg_data;
          CFG_L1: lim[1] <= cfg_data;
          CFG_L2: lim[2] <= cfg_data;
          CFG_L3: lim[3] <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            r <= req.data;
            res <= '{status: ST_OK, task_out: req.data.task_req, level_out: '0};
            if (req.data.kind == K_DISPATCH) begin
              lvl <= '0;
              cur <= head[0];
              steps <= '0;
              state <= S_DSCAN;
            end else if (req.data.kind > K_DISPATCH) begin
              state <= S_OUT;
            end else begin
              state <= S_LVL;
            end
          end
        end
        S_LVL: begin
          // lvl_q valid now
          lvl <= lvl_q;
          cur <= head[lvl_q];
          prev <= NIL;
          steps <= '0;
          unique case (r.kind)
            K_INSERT: begin
              ready_f[r.task_req] <= r.runnable;
              dst <= fit_lvl;
              if (!fit) res.status <= ST_PRIO;
              else res.level_out <= fit_lvl;
              do_app <= 1'b0;
              if (queued[r.task_req]) state <= S_WALK;
              else if (fit) state <= S_APP;
              else state <= S_OUT;
            end
            K_REMOVE: begin
              if (!queued[r.task_req]) begin
                res.status <= ST_NOTQ;
                state <= S_OUT;
              end else begin
                res.level_out <= lvl_q;
                state <= S_WALK;
              end
            end
            K_YIELD: begin
              if (!queued[r.task_req]) begin
                res.status <= ST_NOTQ;
                state <= S_OUT;
              end else begin
                ready_f[r.task_req] <= 1'b1;
                dst <= (lvl_q == LW'(LEVELS-1)) ? lvl_q : lvl_q + 2'd1;
                res.level_out <= (lvl_q == LW'(LEVELS-1)) ? lvl_q : lvl_q + 2'd1;
                do_app <= 1'b0;
                state <= S_WALK;
              end
            end
            default: begin // set runnable
              ready_f[r.task_req] <= r.runnable;
              if (queued[r.task_req]) res.level_out <= lvl_q;
              else res.status <= ST_NOTQ;
              state <= S_OUT;
            end
          endcase
        end
        S_WALK: begin
          if (cur == NIL || steps == 7'(TASKS)) begin
            queued[r.task_req] <= 1'b0;
            state <= (r.kind == K_REMOVE || !fit && r.kind == K_INSERT) ? S_OUT : S_APP;
          end else state <= S_WAIT;
        end
        S_WAIT: begin
          if (cur == {1'b0, r.task_req}) begin
            state <= S_UNL;
          end else begin
            prev <= cur;
            cur <= link_q;
            steps <= steps + 7'd1;
            state <= S_WALK;
          end
        end
        S_UNL: begin
          if (prev == NIL) head[lvl] <= link_q;
          if (tail[lvl] == cur) tail[lvl] <= prev;
          queued[r.task_req] <= 1'b0;
          state <= (r.kind == K_REMOVE || !fit && r.kind == K_INSERT) ? S_OUT : S_APP;
        end
        S_APP: begin
          if (!do_app) begin
            do_app <= 1'b1;
          end else begin
            do_app <= 1'b0;
            if (head[dst] == NIL) head[dst] <= {1'b0, r.task_req};
            tail[dst] <= {1'b0, r.task_req};
            queued[r.task_req] <= 1'b1;
            state <= S_OUT;
          end
        end
        S_DSCAN: begin
          if (cur == NIL || cur >= 7'(TASKS) || steps == 7'(TASKS)) begin
            if (lvl == LW'(LEVELS-1)) begin
              res <= '{status: ST_NONE, task_out: '0, level_out: '0};
              state <= S_OUT;
            end else begin
              lvl <= lvl + 2'd1;
              cur <= head[lvl + 2'd1];
              steps <= '0;
            end
          end else if (ready_f[cur[TW-1:0]]) begin
            ready_f[cur[TW-1:0]] <= 1'b0;
            res <= '{status: ST_OK, task_out: cur[TW-1:0], level_out: lvl};
            state <= S_OUT;
          end else state <= S_DWAIT;
        end
        S_DWAIT: begin
          cur <= link_q;
          steps <= steps + 7'd1;
          state <= S_DSCAN;
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(res)) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !req.ready) else $error("accept while busy");
  a_app_queued: assert property (@(posedge clk) disable iff (rst)
    state == S_APP && do_app |=> queued[r.task_req]) else $error("append lost");
endmodule

// File: tb/testbench.sv
module testbench;
  import mlfq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD = 80;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_L0;
  logic [7:0] cfg_data = '0;

  mlfq_req_if req_ch ();
  mlfq_rsp_if rsp_ch ();

  multilevel_feedback_task_queue uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always #5 clk = ~clk;

  // scheduler state mirror
  logic [7:0] lim [LEVELS];
  logic [6:0] nxt [TASKS];
  logic [6:0] head [LEVELS];
  logic [6:0] tail [LEVELS];
  logic [1:0] lvl_of [TASKS];
  logic queued [TASKS];
  logic ready_f [TASKS];

  req_t pending_ops[$];
  rsp_t due_rsps[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic void sched_reset();
    lim[0] = 8'd1; lim[1] = 8'd3; lim[2] = 8'd5; lim[3] = 8'd7;
    for (int i = 0; i < TASKS; i++) begin
      nxt[i] = '0; lvl_of[i] = '0; queued[i] = 0; ready_f[i] = 0;
    end
    for (int l = 0; l < LEVELS; l++) begin
      head[l] = NIL; tail[l] = NIL;
    end
  endfunction

  function automatic void append_task(int t, int l);
    nxt[t] = NIL;
    if (head[l] == NIL) head[l] = 7'(t);
    else if (tail[l] < TASKS) nxt[tail[l]] = 7'(t);
    tail[l] = 7'(t);
    lvl_of[t] = 2'(l);
    queued[t] = 1;
  endfunction

  function automatic void unlink_task(int t);
    int l;
    int prev;
    int cur;
    int steps;
    l = lvl_of[t];
    prev = NIL;
    cur = head[l];
    steps = 0;
    while (cur < TASKS && steps < TASKS) begin
      if (cur == t) begin
        if (prev == NIL) head[l] = nxt[cur];
        else nxt[prev] = nxt[cur];
        if (tail[l] == cur) tail[l] = 7'(prev);
        break;
      end
      prev = cur;
      cur = nxt[cur];
      steps++;
    end
    queued[t] = 0;
  endfunction

  function automatic rsp_t schedule(req_t r);
    rsp_t o;
    int t;
    int l;
    int cur;
    int steps;
    bit found;
    t = r.task_req;
    o.status = ST_OK;
    o.task_out = r.task_req;
    o.level_out = '0;
    case (r.kind)
      K_INSERT: begin
        found = 0;
        if (queued[t]) unlink_task(t);
        ready_f[t] = r.runnable;
        for (int i = 0; i < LEVELS; i++) begin
          if (!found && r.priority_req <= lim[i]) begin
            append_task(t, i);
            o.level_out = 2'(i);
            found = 1;
          end
        end
        if (!found) o.status = ST_PRIO;
      end
      K_REMOVE: begin
        if (!queued[t]) o.status = ST_NOTQ;
        else begin
          o.level_out = lvl_of[t];
          unlink_task(t);
        end
      end
      K_YIELD: begin
        if (!queued[t]) o.status = ST_NOTQ;
        else begin
          l = lvl_of[t];
          ready_f[t] = 1;
          unlink_task(t);
          if (l + 1 < LEVELS) l++;
          append_task(t, l);
          o.level_out = 2'(l);
        end
      end
      K_SETRUN: begin
        ready_f[t] = r.runnable;
        if (queued[t]) o.level_out = lvl_of[t];
        else o.status = ST_NOTQ;
      end
      K_DISPATCH: begin
        found = 0;
        for (int i = 0; i < LEVELS && !found; i++) begin
          cur = head[i];
          steps = 0;
          while (cur < TASKS && steps < TASKS) begin
            if (ready_f[cur]) begin
              ready_f[cur] = 0;
              o.task_out = 6'(cur);
              o.level_out = 2'(i);
              found = 1;
              break;
            end
            cur = nxt[cur];
            steps++;
          end
        end
        if (!found) begin
          o.status = ST_NONE;
          o.task_out = '0;
          o.level_out = '0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t mk(logic [2:0] k, int t, int p, bit run);
    req_t r;
    r.kind = k;
    r.task_req = 6'(t);
    r.priority_req = 8'(p);
    r.runnable = run;
    return r;
  endfunction

  function automatic req_t random_op();
    int sel;
    logic [2:0] k;
    sel = $urandom_range(0, 99);
    if (sel < 35) k = K_INSERT;
    else if (sel < 50) k = K_REMOVE;
    else if (sel < 65) k = K_YIELD;
    else if (sel < 78) k = K_SETRUN;
    else if (sel < 96) k = K_DISPATCH;
    else k = 3'($urandom_range(5, 7));
    // mostly a small task pool so lists get long and ops hit queued tasks
    return mk(k, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11),
              ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 9),
              $urandom_range(0, 1));
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else if (req_ch.valid && !req_ch.ready) begin
    end else if (send_gap > 0) begin
      req_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      req_ch.valid <= 1'b0;
      send_gap <= $urandom_range(0, 18);
    end else if (pending_ops.size() > 0) begin
      req_ch.valid <= 1'b1;
      req_ch.data <= pending_ops[0];
      due_rsps.push_back(schedule(pending_ops.pop_front()));
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_rsps.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected item %p", rsp_ch.data);
        end else begin
          want = due_rsps.pop_front();
          if (rsp_ch.data !== want) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: expected st=%0d task=%0d lvl=%0d, got st=%0d task=%0d lvl=%0d",
                       want.status, want.task_out, want.level_out, rsp_ch.data.status,
                       rsp_ch.data.task_out, rsp_ch.data.level_out);
          end
        end
      end
      if (recv_gap > 0) begin
        rsp_ch.ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        rsp_ch.ready <= 1'b0;
        recv_gap <= $urandom_range(0, 18);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic drain();
    while (pending_ops.size() > 0 || req_ch.valid || due_rsps.size() > 0) @(posedge clk);
    repeat (HOLD) @(posedge clk);
  endtask

  task automatic set_limit(logic [1:0] idx, logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    lim[idx] = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic burst(int n);
    for (int i = 0; i < n; i++) pending_ops.push_back(random_op());
  endtask

  initial begin
    sched_reset();
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty dispatch, not-queued paths, extremes, undefined kinds
    pending_ops.push_back(mk(K_DISPATCH, 63, 255, 1));
    pending_ops.push_back(mk(K_REMOVE, 5, 0, 0));
    pending_ops.push_back(mk(K_YIELD, 63, 0, 0));
    pending_ops.push_back(mk(K_SETRUN, 9, 0, 1));
    pending_ops.push_back(mk(K_INSERT, 0, 0, 0));
    pending_ops.push_back(mk(K_INSERT, 63, 7, 1));
    pending_ops.push_back(mk(K_INSERT, 21, 3, 1));
    pending_ops.push_back(mk(K_INSERT, 42, 5, 1));
    pending_ops.push_back(mk(K_INSERT, 9, 1, 1));
    pending_ops.push_back(mk(K_INSERT, 7, 255, 1));
    pending_ops.push_back(mk(K_INSERT, 21, 8, 0));
    pending_ops.push_back(mk(K_INSERT, 0, 2, 1));
    pending_ops.push_back(mk(K_SETRUN, 0, 0, 0));
    pending_ops.push_back(mk(K_YIELD, 9, 0, 0));
    pending_ops.push_back(mk(K_YIELD, 63, 0, 0));
    pending_ops.push_back(mk(K_DISPATCH, 0, 0, 0));
    pending_ops.push_back(mk(K_DISPATCH, 0, 0, 0));
    pending_ops.push_back(mk(K_REMOVE, 42, 0, 0));
    pending_ops.push_back(mk(K_REMOVE, 0, 0, 0));
    pending_ops.push_back(mk(3'd5, 33, 170, 1));
    pending_ops.push_back(mk(3'd7, 12, 85, 0));
    pending_ops.push_back(mk(K_DISPATCH, 0, 0, 0));
    pending_ops.push_back(mk(K_DISPATCH, 0, 0, 0));
    drain();

    burst(400);
    drain();   // sender holds off until everything is back

    set_limit(CFG_L0, 8'd0);
    set_limit(CFG_L1, 8'd0);
    set_limit(CFG_L2, 8'd4);
    set_limit(CFG_L3, 8'd255);
    burst(400);
    drain();

    set_limit(CFG_L0, 8'd255);
    set_limit(CFG_L1, 8'd255);
    set_limit(CFG_L2, 8'd255);
    set_limit(CFG_L3, 8'd255);
    burst(300);
    drain();

    set_limit(CFG_L0, 8'd2);
    set_limit(CFG_L1, 8'd128);
    set_limit(CFG_L2, 8'd200);
    set_limit(CFG_L3, 8'd0);
    burst(400);
    drain();

    set_limit(CFG_L0, 8'd1);
    set_limit(CFG_L1, 8'd3);
    set_limit(CFG_L2, 8'd5);
    set_limit(CFG_L3, 8'd7);
    calm = 1;
    burst(330);
    drain();

    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule

// File: filelist.f
hdl/mlfq_pkg.sv
hdl/mlfq_if.sv
hdl/multilevel_feedback_task_queue.sv
tb/testbench.sv
